// ----- design/flpte_pkg.sv -----
// Package for the four-level page table engine.
// Holds the store geometry, status and op codes, and entry bit positions. No dependencies.
package flpte_pkg;
    localparam int STORE_FRAMES      = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int FRAME_W           = $clog2(STORE_FRAMES);
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int ENTRY_AW          = FRAME_W + IDX_W;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVAL    = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOMEM    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_UNMAP = 2'd2;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_ROOT  = 2'd1;
    localparam logic [1:0] CFG_FIRST = 2'd2;
    localparam logic [1:0] CFG_AEN   = 2'd3;

    localparam int PTE_P  = 0;
    localparam int PTE_W  = 1;
    localparam int PTE_PS = 7;
    localparam logic [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] FLAGS_MASK = 64'h8000_0000_0000_011E;

    // Table index of vaddr at walk level 0..3 (PML4, PDPT, PD, PT).
    function automatic logic [IDX_W-1:0] level_index(input logic [63:0] v,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] r;
        case (lvl)
            2'd0:    r = v[47:39];
            2'd1:    r = v[38:30];
            2'd2:    r = v[29:21];
            default: r = v[20:12];
        endcase
        return r;
    endfunction
endpackage

// ----- design/four_level_page_table_engine_unit.sv -----
// Four-level page table engine, top level.
// Each walk level reads its table entry (S_RD) and evaluates it (S_EV); S_FIN then loads
//   the result into the output register behind m_tvalid. Each table allocated on map adds
//   512 zeroing writes plus one parent write. A bad request skips the walk and goes to S_FIN.
// One request at a time: a new one is taken only in idle, once S_FIN has loaded the last
//   result, and S_FIN waits while the output register still holds an unaccepted result.
// Reset (aresetn low, synchronous): control and config registers to reset values, then a
//   clearing pass zeroes all 32768 store entries; no request is taken until it ends.
// Depends on flpte_pkg.
module four_level_page_table_engine_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], vaddr[65:2], map_paddr[129:66], map_flags[193:130], zero pad
    input  logic [199:0] s_tdata,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], out_vaddr[66:3], found_paddr[118:67], found_flags[182:119],
    // invalidate[183]
    output logic [183:0] m_tdata,
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [39:0]  cfg_wr_data
);
    localparam int FW  = flpte_pkg::FRAME_W;
    localparam int IW  = flpte_pkg::IDX_W;
    localparam int AW  = flpte_pkg::ENTRY_AW;
    localparam int NENT = flpte_pkg::STORE_FRAMES * flpte_pkg::ENTRIES_PER_TABLE;

    localparam logic [2:0] S_CLR  = 3'd0; // reset clearing pass
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2; // issue table read
    localparam logic [2:0] S_EV   = 3'd3; // evaluate entry
    localparam logic [2:0] S_ZERO = 3'd4; // zero a new table
    localparam logic [2:0] S_LINK = 3'd5; // write parent entry of new table
    localparam logic [2:0] S_FIN  = 3'd6; // hand result to output register

    // table store: one write and one registered read port
    logic [63:0]   mem [NENT];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // config
    logic [39:0] base_reg;
    logic [5:0]  root_reg;
    logic [6:0]  first_reg;
    logic        aen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            root_reg  <= '0;
            first_reg <= 7'd1;
            aen_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                flpte_pkg::CFG_BASE:  base_reg  <= cfg_wr_data;
                flpte_pkg::CFG_ROOT:  root_reg  <= cfg_wr_data[5:0];
                flpte_pkg::CFG_FIRST: first_reg <= cfg_wr_data[6:0];
                flpte_pkg::CFG_AEN:   aen_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [AW-1:0] slot_reg, slot_next;    // address of entry being examined
    logic [IW-1:0] zcnt_reg, zcnt_next;
    logic [6:0]    cnt_reg, cnt_next;      // frames handed out
    logic [1:0]    op_reg, op_next;
    logic [63:0]   va_reg, va_next, pa_reg, pa_next, fl_reg, fl_next;
    logic [2:0]    st_reg, st_next;
    logic [51:0]   fpa_reg, fpa_next;
    logic [63:0]   ffl_reg, ffl_next;
    logic          inv_reg, inv_next;
    logic          mv_reg, mv_next;
    logic [183:0]  mdata_reg, mdata_next;

    // request decode
    logic [1:0]  in_op;
    logic [63:0] in_va, in_pa;
    logic        in_bad;
    assign in_op = s_tdata[1:0];
    assign in_va = s_tdata[65:2];
    assign in_pa = s_tdata[129:66];
    assign in_bad = (in_op != flpte_pkg::OP_MAP && in_op != flpte_pkg::OP_QUERY &&
                     in_op != flpte_pkg::OP_UNMAP)
                  || !((in_va[63:47] == '0) || (in_va[63:47] == '1))
                  || (in_va[11:0] != '0)
                  || (in_op == flpte_pkg::OP_MAP && in_pa[11:0] != '0)
                  || (32'(root_reg) >= flpte_pkg::STORE_FRAMES);

    // entry target frame: pfn - base, must fall inside the store
    logic [40:0] diff;
    logic        diff_ok;
    assign diff    = {1'b0, mem_rdata[51:12]} - {1'b0, base_reg};
    assign diff_ok = !diff[40] && (diff[39:0] < 40'(flpte_pkg::STORE_FRAMES));

    // allocator
    logic [7:0]  nf;
    logic        alloc_ok;
    logic [39:0] link_pfn;
    assign nf       = {1'b0, first_reg} + {1'b0, cnt_reg};
    assign alloc_ok = aen_reg && (cnt_reg != 7'd127) && (32'(nf) < flpte_pkg::STORE_FRAMES);
    assign link_pfn = base_reg + 40'(frame_reg);

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        lvl_next   = lvl_reg;
        frame_next = frame_reg;
        slot_next  = slot_reg;
        zcnt_next  = zcnt_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        va_next    = va_reg;
        pa_next    = pa_reg;
        fl_next    = fl_reg;
        st_next    = st_reg;
        fpa_next   = fpa_reg;
        ffl_next   = ffl_reg;
        inv_next   = inv_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = '0;
        mem_raddr  = {frame_reg, flpte_pkg::level_index(va_reg, lvl_reg)};

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = in_op;
                    va_next    = in_va;
                    pa_next    = in_pa;
                    fl_next    = s_tdata[193:130];
                    fpa_next   = '0;
                    ffl_next   = '0;
                    inv_next   = 1'b0;
                    lvl_next   = 2'd0;
                    frame_next = FW'(root_reg);
                    if (in_bad) begin
                        st_next    = flpte_pkg::ST_INVAL;
                        state_next = S_FIN;
                    end else begin
                        st_next    = flpte_pkg::ST_OK;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                slot_next  = mem_raddr;
                state_next = S_EV;
            end
            S_EV: begin
                state_next = S_FIN;
                if (lvl_reg != 2'd3) begin
                    if (mem_rdata[flpte_pkg::PTE_P]) begin
                        if (mem_rdata[flpte_pkg::PTE_PS]) begin
                            st_next = (op_reg == flpte_pkg::OP_MAP) ? flpte_pkg::ST_EXISTS
                                                                   : flpte_pkg::ST_NOTFOUND;
                        end else if (!diff_ok) begin
                            st_next = flpte_pkg::ST_INVAL;
                        end else begin
                            frame_next = diff[FW-1:0];
                            lvl_next   = lvl_reg + 2'd1;
                            state_next = S_RD;
                        end
                    end else if (op_reg != flpte_pkg::OP_MAP) begin
                        st_next = flpte_pkg::ST_NOTFOUND;
                    end else if (!alloc_ok) begin
                        st_next = flpte_pkg::ST_NOMEM;
                    end else begin
                        cnt_next   = cnt_reg + 7'd1;
                        frame_next = nf[FW-1:0];
                        zcnt_next  = '0;
                        state_next = S_ZERO;
                    end
                end else begin
                    // leaf entry
                    case (op_reg)
                        flpte_pkg::OP_MAP: begin
                            if (mem_rdata[flpte_pkg::PTE_P]) begin
                                st_next = flpte_pkg::ST_EXISTS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = (pa_reg & flpte_pkg::ADDR_MASK)
                                          | (fl_reg & flpte_pkg::FLAGS_MASK) | 64'd1;
                            end
                        end
                        flpte_pkg::OP_QUERY: begin
                            if (!mem_rdata[flpte_pkg::PTE_P]) begin
                                st_next = flpte_pkg::ST_NOTFOUND;
                            end else begin
                                fpa_next = mem_rdata[51:0] & flpte_pkg::ADDR_MASK[51:0];
                                ffl_next = mem_rdata & ~flpte_pkg::ADDR_MASK;
                            end
                        end
                        default: begin
                            if (!mem_rdata[flpte_pkg::PTE_P]) begin
                                st_next = flpte_pkg::ST_NOTFOUND;
                            end else begin
                                mem_we   = 1'b1;
                                inv_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = {frame_reg, zcnt_reg};
                zcnt_next = zcnt_reg + 1'b1;
                if (zcnt_reg == '1) begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                // parent written after the zeroing, so a reused parent frame still links
                mem_we     = 1'b1;
                mem_wdata  = {12'd0, link_pfn, 12'd0} | 64'd3;
                lvl_next   = lvl_reg + 2'd1;
                state_next = S_RD;
            end
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {inv_reg, ffl_reg, fpa_reg, va_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg   <= lvl_next;
        frame_reg <= frame_next;
        slot_reg  <= slot_next;
        zcnt_reg  <= zcnt_next;
        op_reg    <= op_next;
        va_reg    <= va_next;
        pa_reg    <= pa_next;
        fl_reg    <= fl_next;
        st_reg    <= st_next;
        fpa_reg   <= fpa_next;
        ffl_reg   <= ffl_next;
        inv_reg   <= inv_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    a_no_req_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("request taken during clearing pass");
    a_alloc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + 7'd1))
        else $error("allocation counter moved by more than one");
    a_inv_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && mdata_reg[183]) |-> (mdata_reg[2:0] == flpte_pkg::ST_OK))
        else $error("invalidate on failed request");
    a_zero_then_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ZERO && zcnt_reg == '1) |=> (state_reg == S_LINK))
        else $error("table zeroing did not end in parent link");
endmodule

// ----- bench/four_level_page_table_engine_unit_test.sv -----
// Self-checking bench for the four-level page table engine: directed, random and stall tests.
// Keeps its own page table store and allocator model to predict every response.
// Depends on flpte_pkg and four_level_page_table_engine_unit.
module four_level_page_table_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Idle-cycle watchdog; the post-reset clearing pass alone zeroes all 32768 store entries.
    localparam int IDLE_LIMIT = 200000;
    localparam int NENT = flpte_pkg::STORE_FRAMES * flpte_pkg::ENTRIES_PER_TABLE;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] vaddr;
        logic [51:0] paddr;
        logic [63:0] flags;
        logic        inval;
    } walk_resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr = flpte_pkg::CFG_BASE;
    logic [39:0]  cfg_wr_data = '0;

    four_level_page_table_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- shadow of the engine state ----------------
    logic [63:0] shadow_tables [0:NENT-1];
    int          tables_handed_out;
    logic [39:0] base_frame;
    logic [5:0]  root_idx;
    logic [6:0]  first_free;
    logic        alloc_en;

    walk_resp_t  pending_resp [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;     // cycles the receiver must still hold off

    // Store frame index for a physical address; 0 when it falls outside the store.
    function automatic bit store_frame(input logic [63:0] pa, output int f);
        logic [63:0] pfn;
        pfn = pa >> 12;
        f = 0;
        if (pfn < {24'b0, base_frame}) return 1'b0;
        pfn = pfn - {24'b0, base_frame};
        if (pfn >= flpte_pkg::STORE_FRAMES) return 1'b0;
        f = int'(pfn);
        return 1'b1;
    endfunction

    // Walks the shadow tables exactly as the engine does and applies any side effects.
    task automatic walk_request(input logic [1:0] op, input logic [63:0] v,
                                input logic [63:0] pa, input logic [63:0] fl,
                                output walk_resp_t r);
        int          t, f, s, nf, lv;
        logic [63:0] e;
        logic [2:0]  st;
        st = flpte_pkg::ST_OK;
        r = '0;
        r.vaddr = v;
        if (op > flpte_pkg::OP_UNMAP || v[63:48] != {16{v[47]}} || v[11:0] != 0 ||
            (op == flpte_pkg::OP_MAP && pa[11:0] != 0) ||
            root_idx >= flpte_pkg::STORE_FRAMES) begin
            st = flpte_pkg::ST_INVAL;
        end else begin
            t = int'(root_idx);
            for (lv = 0; lv < 3 && st == flpte_pkg::ST_OK; lv++) begin
                s = t * flpte_pkg::ENTRIES_PER_TABLE + int'((v >> (39 - 9 * lv)) & 64'h1FF);
                e = shadow_tables[s];
                if (e[flpte_pkg::PTE_P]) begin
                    // huge upper entry: exists on map, not found otherwise
                    if (e[flpte_pkg::PTE_PS])
                        st = (op == flpte_pkg::OP_MAP) ? flpte_pkg::ST_EXISTS
                                                       : flpte_pkg::ST_NOTFOUND;
                    else if (!store_frame(e & flpte_pkg::ADDR_MASK, f))
                        st = flpte_pkg::ST_INVAL;
                    else t = f;
                end else if (op != flpte_pkg::OP_MAP) begin
                    st = flpte_pkg::ST_NOTFOUND;
                end else begin
                    nf = int'(first_free) + tables_handed_out;
                    if (!alloc_en || tables_handed_out >= 127 ||
                        nf >= flpte_pkg::STORE_FRAMES) begin
                        st = flpte_pkg::ST_NOMEM;
                    end else begin
                        tables_handed_out++;
                        for (int k = 0; k < flpte_pkg::ENTRIES_PER_TABLE; k++)
                            shadow_tables[nf * flpte_pkg::ENTRIES_PER_TABLE + k] = '0;
                        shadow_tables[s] = ((({24'b0, base_frame} + 64'(nf)) << 12)
                                            & flpte_pkg::ADDR_MASK) | 64'h3;
                        t = nf;
                    end
                end
            end
            if (st == flpte_pkg::ST_OK) begin
                s = t * flpte_pkg::ENTRIES_PER_TABLE + int'(v[20:12]);
                e = shadow_tables[s];
                if (op == flpte_pkg::OP_MAP) begin
                    if (e[flpte_pkg::PTE_P]) st = flpte_pkg::ST_EXISTS;
                    else shadow_tables[s] = (pa & flpte_pkg::ADDR_MASK) | 64'h1
                                            | (fl & flpte_pkg::FLAGS_MASK);
                end else if (!e[flpte_pkg::PTE_P]) begin
                    st = flpte_pkg::ST_NOTFOUND;
                end else if (op == flpte_pkg::OP_QUERY) begin
                    r.paddr = e[51:0] & flpte_pkg::ADDR_MASK[51:0];
                    r.flags = e & ~flpte_pkg::ADDR_MASK;
                end else begin
                    shadow_tables[s] = '0;
                    r.inval = 1'b1;
                end
            end
        end
        r.status = st;
    endtask

    // ---------------- driving ----------------
    // Offers one request; returns at the edge it is taken, with tvalid still high.
    task automatic send_request(input logic [1:0] op, input logic [63:0] v,
                                input logic [63:0] pa, input logic [63:0] fl);
        walk_resp_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, fl, pa, v, op};
        do @(posedge aclk); while (!s_tready);
        walk_request(op, v, pa, fl, r);
        pending_resp.push_back(r);
    endtask

    // Wait until every response is back and the engine has gone quiet.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            flpte_pkg::CFG_BASE:  base_frame = val;
            flpte_pkg::CFG_ROOT:  root_idx   = val[5:0];
            flpte_pkg::CFG_FIRST: first_free = val[6:0];
            default:              alloc_en   = val[0];
        endcase
    endtask

    // Page-aligned canonical address built from table indexes; upper half when l4[8].
    function automatic logic [63:0] page_va(input logic [8:0] l4, input logic [8:0] l3,
                                            input logic [8:0] l2, input logic [8:0] l1);
        return {{16{l4[8]}}, l4, l3, l2, l1, 12'h000};
    endfunction

    // Mostly well-formed requests over a small address pool so tables get shared and
    // leaves get hit again; the rest is raw noise.
    task automatic random_request;
        logic [1:0]  op;
        logic [63:0] v, pa, fl;
        logic [8:0]  l4, l3, l2, l1;
        int          pick;
        pick = $urandom_range(99);
        pa = {$urandom, $urandom};
        fl = {$urandom, $urandom};
        if (pick < 8) begin
            op = 2'($urandom_range(3));
            v  = {$urandom, $urandom};
        end else begin
            op = (pick < 55) ? flpte_pkg::OP_MAP :
                 (pick < 80) ? flpte_pkg::OP_QUERY : flpte_pkg::OP_UNMAP;
            case ($urandom_range(2))
                0: l4 = 9'd0;
                1: l4 = 9'd511;
                default: l4 = 9'd300;
            endcase
            l3 = $urandom_range(1) ? 9'd0 : 9'd511;
            case ($urandom_range(2))
                0: l2 = 9'd0;
                1: l2 = 9'd1;
                default: l2 = 9'd511;
            endcase
            l1 = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(15));
            v = page_va(l4, l3, l2, l1);
            if ($urandom_range(19) != 0) pa[11:0] = 12'h000;
        end
        send_request(op, v, pa, fl);
    endtask

    // ---------------- response side ----------------
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            m_tready  <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 40)
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin
        walk_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response vaddr", m_tdata[66:3], '0);
            end else begin
                want = pending_resp.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", 64'(m_tdata[2:0]), 64'(want.status));
                if (m_tdata[66:3] != want.vaddr)
                    report_mismatch("vaddr", m_tdata[66:3], want.vaddr);
                if (m_tdata[118:67] != want.paddr)
                    report_mismatch("paddr", 64'(m_tdata[118:67]), 64'(want.paddr));
                if (m_tdata[182:119] != want.flags)
                    report_mismatch("flags", m_tdata[182:119], want.flags);
                if (m_tdata[183] != want.inval)
                    report_mismatch("invalidate", 64'(m_tdata[183]), 64'(want.inval));
            end
        end
    end

    // Watchdog: cycles with no handshake on either side and no register write.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- tests ----------------
    // Field extremes, every op and each corner of the walk.
    task automatic test_directed;
        logic [63:0] top_va;
        top_va = 64'hFFFF_FFFF_FFFF_F000;
        send_request(flpte_pkg::OP_QUERY, 64'h0, '0, '0);      // nothing mapped yet
        send_request(flpte_pkg::OP_MAP, 64'h0, 64'h0, '1);     // allocates three tables
        send_request(flpte_pkg::OP_MAP, 64'h0, 64'h5000, '0);  // leaf already present
        send_request(flpte_pkg::OP_QUERY, 64'h0, '1, '1);
        send_request(flpte_pkg::OP_MAP, top_va, 64'hFFFF_FFFF_FFFF_F000, '0); // top bits dropped
        send_request(flpte_pkg::OP_QUERY, top_va, '0, '0);
        send_request(flpte_pkg::OP_UNMAP, 64'h0, '0, '0);
        send_request(flpte_pkg::OP_UNMAP, 64'h0, '0, '0);      // leaf absent
        send_request(2'd3, 64'h0, '0, '0);                     // undefined op
        send_request(flpte_pkg::OP_QUERY, 64'h0000_8000_0000_0000, '0, '0); // non-canonical
        send_request(flpte_pkg::OP_QUERY, 64'h0000_0000_0000_1001, '0, '0); // unaligned vaddr
        send_request(flpte_pkg::OP_MAP, 64'h2000, 64'h800, '0); // unaligned paddr
        drain();
        write_reg(flpte_pkg::CFG_AEN, 40'd0);
        send_request(flpte_pkg::OP_MAP, 64'h0000_7FFF_FFFF_F000, 64'h1000, '0); // allocator off
        drain();
        write_reg(flpte_pkg::CFG_AEN, 40'd1);
        write_reg(flpte_pkg::CFG_BASE, 40'hFF_FFFF_FFFF);
        send_request(flpte_pkg::OP_QUERY, top_va, '0, '0);     // tables fall outside store
        send_request(flpte_pkg::OP_MAP, top_va, 64'h3000, '0);
        drain();
        write_reg(flpte_pkg::CFG_BASE, 40'd0);
        write_reg(flpte_pkg::CFG_ROOT, 40'd63);
        send_request(flpte_pkg::OP_MAP, 64'h0, 64'h7000, 64'h8000_0000_0000_0006);
        send_request(flpte_pkg::OP_QUERY, 64'h0, '0, '0);
        drain();
        write_reg(flpte_pkg::CFG_FIRST, 40'd64);
        send_request(flpte_pkg::OP_MAP, 64'h0000_7000_0000_0000, 64'h1000, '0); // past store
        drain();
        // rewind the allocator over tables in use: they get zeroed and reused
        write_reg(flpte_pkg::CFG_FIRST, 40'd0);
        send_request(flpte_pkg::OP_MAP, 64'h0000_0080_0000_0000, 64'h2000, '1);
        send_request(flpte_pkg::OP_QUERY, top_va, '0, '0);
        drain();
        write_reg(flpte_pkg::CFG_ROOT, 40'd0);
        write_reg(flpte_pkg::CFG_FIRST, 40'd1);
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) random_request();
        drain();
    endtask

    // Receiver holds off while requests keep coming, so the input stalls.
    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 400;
        repeat (30) random_request();
        drain();
    endtask

    // Random traffic under a sequence of register settings, extremes included.
    task automatic test_config_sweep;
        write_reg(flpte_pkg::CFG_BASE, 40'd0);
        write_reg(flpte_pkg::CFG_ROOT, 40'd32);
        test_random(120, 85, 14);
        write_reg(flpte_pkg::CFG_BASE, 40'hFF_FFFF_FFFF);
        write_reg(flpte_pkg::CFG_ROOT, 40'd0);
        test_random(60, 85, 14);
        write_reg(flpte_pkg::CFG_BASE, 40'd0);
        write_reg(flpte_pkg::CFG_AEN, 40'd0);
        test_random(80, 85, 14);
        write_reg(flpte_pkg::CFG_AEN, 40'd1);
        write_reg(flpte_pkg::CFG_FIRST, 40'd64);
        test_random(60, 85, 14);
        write_reg(flpte_pkg::CFG_FIRST, 40'd1);
        write_reg(flpte_pkg::CFG_ROOT, 40'd63);
        test_random(120, 85, 14);
        write_reg(flpte_pkg::CFG_ROOT, 40'd0);
    endtask

    initial begin
        for (int i = 0; i < NENT; i++) shadow_tables[i] = '0;
        tables_handed_out = 0;
        base_frame = '0;
        root_idx   = '0;
        first_free = 7'd1;
        alloc_en   = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(350, 14, 85);
        test_backpressure();
        test_config_sweep();
        test_random(300, 0, 0);

        drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_resp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
